### rtl/sab_pkg.sv
// Shared types and constants for the source address blocklist.
// Used by the controller, the datapath, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sab_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 8;
	localparam int KIND_W  = 2;
	localparam int RESULT_W = COUNT_W + 4;
	localparam int OUT_DATA_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHECK = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_FAIL  = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] attempt_count;
		logic               table_full;
		logic               over_limit;
		logic               drop;
		logic               found;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/sab_ctrl.sv
// Controller state machine for the source address blocklist.
// Depends on sab_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module sab_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire sab_pkg::stat_t   stat,
	output sab_pkg::cmd_t         cmd
);

	sab_pkg::state_t state_q;
	sab_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sab_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			sab_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sab_pkg::ST_SCAN;
				end
			end
			sab_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done && stat.out_free) begin
					cmd.update = 1'b1;
					state_d    = sab_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sab_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/sab_datapath.sv
// Datapath of the source address blocklist: table memory, scan pipeline,
// update logic, limit register and result register. Depends on sab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sab_datapath #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire sab_pkg::cmd_t                 cmd,
	output sab_pkg::stat_t                     stat,
	input  wire [sab_pkg::KIND_W-1:0]          in_kind,
	input  wire [sab_pkg::ADDR_W-1:0]          in_addr,
	input  wire                                cfg_we,
	input  wire [sab_pkg::COUNT_W-1:0]         cfg_wdata,
	input  wire                                out_ready,
	output logic                               out_valid,
	output sab_pkg::result_t                   out_result
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	sab_pkg::entry_t mem_q [TABLE_DEPTH];

	logic [CNT_W-1:0]            used_q;
	logic [CNT_W-1:0]            rd_idx_q;
	logic                        rd_valid_s1;
	logic [IDX_W-1:0]            idx_s1;
	sab_pkg::entry_t             rdata_s1;
	logic                        hit_q;
	logic [IDX_W-1:0]            hit_idx_q;
	logic [sab_pkg::COUNT_W-1:0] hit_count_q;
	sab_pkg::kind_t              kind_q;
	logic [sab_pkg::ADDR_W-1:0]  addr_q;
	logic [sab_pkg::COUNT_W-1:0] limit_q;
	logic                        out_valid_q;
	sab_pkg::result_t            out_q;

	logic                        match;
	logic                        mem_re;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	sab_pkg::entry_t             mem_wdata;
	logic                        used_inc;
	logic [sab_pkg::COUNT_W-1:0] count_inc;
	logic                        hit_over;
	sab_pkg::result_t            result_d;

	assign match  = rd_valid_s1 && !hit_q && (rdata_s1.addr == addr_q);
	assign mem_re = cmd.scan && !hit_q && !match && (rd_idx_q < used_q);

	assign stat.scan_done = hit_q || ((rd_idx_q == used_q) && !rd_valid_s1);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign count_inc = (hit_count_q == sab_pkg::COUNT_MAX) ?
		hit_count_q : hit_count_q + 8'd1;
	assign hit_over  = hit_count_q > limit_q;

	always_comb begin
		result_d  = '0;
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = '0;
		used_inc  = 1'b0;
		case (kind_q)
			sab_pkg::KIND_CHECK: begin
				if (hit_q) begin
					result_d.found         = 1'b1;
					result_d.attempt_count = hit_count_q;
					result_d.over_limit    = hit_over;
					result_d.drop          = hit_over;
				end
			end
			sab_pkg::KIND_ADD: begin
				if (hit_q) begin
					result_d.found         = 1'b1;
					result_d.attempt_count = hit_count_q;
					result_d.over_limit    = hit_over;
				end else if (used_q < DEPTH_CNT) begin
					mem_we          = cmd.update;
					mem_waddr       = used_q[IDX_W-1:0];
					mem_wdata.addr  = addr_q;
					mem_wdata.count = '0;
					used_inc        = cmd.update;
					result_d.found  = 1'b1;
				end else begin
					result_d.table_full = 1'b1;
				end
			end
			sab_pkg::KIND_FAIL: begin
				if (hit_q) begin
					mem_we                 = cmd.update;
					mem_waddr              = hit_idx_q;
					mem_wdata.addr         = addr_q;
					mem_wdata.count        = count_inc;
					result_d.found         = 1'b1;
					result_d.attempt_count = count_inc;
					result_d.over_limit    = count_inc > limit_q;
				end
			end
			default: begin
				result_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[rd_idx_q[IDX_W-1:0]];
			idx_s1   <= rd_idx_q[IDX_W-1:0];
		end
		if (cmd.load) begin
			kind_q <= sab_pkg::kind_t'(in_kind);
			addr_q <= in_addr;
		end
		if (match) begin
			hit_idx_q   <= idx_s1;
			hit_count_q <= rdata_s1.count;
		end
		if (cmd.update) begin
			out_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			limit_q     <= sab_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.load) begin
				rd_idx_q    <= '0;
				rd_valid_s1 <= 1'b0;
				hit_q       <= 1'b0;
			end else begin
				rd_valid_s1 <= mem_re;
				if (mem_re) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule

`default_nettype wire

### rtl/source_address_blocklist.sv
// A request is compared with the used table entries in order until the first hit; a miss
// scans every used entry. The result is written once the output register is free.
// The scan reads one table entry per cycle; a new request is taken only after that result.
// The next request is taken while the previous result waits in the output register.
// Reset: arst_n clears the table (no entries), the control state and the result
// valid, and sets attempt_limit to 3; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module source_address_blocklist #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [31:0] s_tdata,   // [31:0] source_addr
	input  wire [1:0]  s_tuser,   // [1:0] kind
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata,  // [0] found, [1] drop, [2] over_limit,
	                              // [3] table_full, [11:4] attempt_count, [15:12] zero
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata
);

	sab_pkg::cmd_t    cmd;
	sab_pkg::stat_t   stat;
	sab_pkg::result_t result;

	sab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sab_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_tuser),
		.in_addr    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_result (result)
	);

	assign m_tdata = {(sab_pkg::OUT_DATA_W - sab_pkg::RESULT_W)'(0), result};

endmodule

`default_nettype wire

### rtl/sab_checker.sv
// Port-level checker for the source address blocklist and its bind.
// Depends on the top-level port list only.
`timescale 1ns / 1ps
`default_nettype none

module sab_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);

	// A held result must not change while the consumer stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A request starts a table scan, so the input is closed in the cycle after it is taken.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken during scan");

	// A full table and a found entry exclude each other.
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[3] && m_tdata[0]))
		else $error("table_full with found");

	// Drop and over-limit only come from a present entry.
	a_drop_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[1] || m_tdata[2]) && (!m_tdata[2] || m_tdata[0]))
		else $error("drop or over_limit without a found entry");

endmodule

bind source_address_blocklist sab_checker u_sab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the source address blocklist.
// It needs sab_pkg and source_address_blocklist, and it predicts each result
// with its own table model unless a directed row gives the expected result.
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_REQUESTS = 170;
	localparam logic [sab_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam sab_pkg::result_t NOTHING = '0;
	localparam sab_pkg::result_t FOUND_FRESH = 12'h001;

	typedef struct packed {
		logic [sab_pkg::KIND_W-1:0] kind;
		logic [sab_pkg::ADDR_W-1:0] addr;
		logic                       typed;
		sab_pkg::result_t           want;
	} directed_t;

	localparam int DIRECTED_N = 19;
	localparam directed_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{sab_pkg::KIND_CHECK, 32'h0000_0000, 1'b1, NOTHING},
		'{sab_pkg::KIND_FAIL,  32'hFFFF_FFFF, 1'b1, NOTHING},
		'{KIND_UNUSED,         32'hFFFF_FFFF, 1'b1, NOTHING},
		'{sab_pkg::KIND_ADD,   32'h0000_0000, 1'b1, FOUND_FRESH},
		'{sab_pkg::KIND_ADD,   32'hFFFF_FFFF, 1'b1, FOUND_FRESH},
		'{sab_pkg::KIND_ADD,   32'h0000_0000, 1'b1, FOUND_FRESH},
		'{sab_pkg::KIND_FAIL,  32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_FAIL,  32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_FAIL,  32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_CHECK, 32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_FAIL,  32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_CHECK, 32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_CHECK, 32'h0000_0000, 1'b0, NOTHING},
		'{KIND_UNUSED,         32'h0000_0000, 1'b1, NOTHING},
		'{sab_pkg::KIND_ADD,   32'hFFFF_FFFF, 1'b0, NOTHING},
		'{sab_pkg::KIND_FAIL,  32'h0000_0000, 1'b0, NOTHING},
		'{sab_pkg::KIND_CHECK, 32'h8000_0001, 1'b1, NOTHING},
		'{sab_pkg::KIND_ADD,   32'hA5A5_5A5A, 1'b0, NOTHING},
		'{sab_pkg::KIND_FAIL,  32'h5A5A_A5A5, 1'b1, NOTHING}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	logic [sab_pkg::ADDR_W-1:0]  tbl_addr [TABLE_DEPTH];
	logic [sab_pkg::COUNT_W-1:0] tbl_count [TABLE_DEPTH];
	int                          n_used = 0;
	logic [sab_pkg::COUNT_W-1:0] limit_model = sab_pkg::LIMIT_RESET;

	sab_pkg::result_t expected_results [$];
	bit steady = 1'b0;
	int sent = 0;
	int settings = 1;
	int mismatches = 0;
	int n_drop = 0;
	int n_full = 0;
	int n_sat = 0;
	int quiet_cycles = 0;

	source_address_blocklist #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic sab_pkg::result_t predict_blocklist(
			input logic [sab_pkg::KIND_W-1:0] kind,
			input logic [sab_pkg::ADDR_W-1:0] addr);
		sab_pkg::result_t r;
		int hit;
		int i;
		r = '0;
		hit = -1;
		for (i = n_used - 1; i >= 0; i--)
			if (tbl_addr[i] == addr)
				hit = i;
		case (kind)
			sab_pkg::KIND_CHECK: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.attempt_count = tbl_count[hit];
					r.over_limit = tbl_count[hit] > limit_model;
					r.drop = r.over_limit;
				end
			end
			sab_pkg::KIND_ADD: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.attempt_count = tbl_count[hit];
					r.over_limit = tbl_count[hit] > limit_model;
				end else if (n_used < TABLE_DEPTH) begin
					tbl_addr[n_used] = addr;
					tbl_count[n_used] = '0;
					n_used++;
					r.found = 1'b1;
				end else begin
					r.table_full = 1'b1;
				end
			end
			sab_pkg::KIND_FAIL: begin
				if (hit >= 0) begin
					if (tbl_count[hit] != sab_pkg::COUNT_MAX)
						tbl_count[hit] = tbl_count[hit] + 1'b1;
					r.found = 1'b1;
					r.attempt_count = tbl_count[hit];
					r.over_limit = tbl_count[hit] > limit_model;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [sab_pkg::KIND_W-1:0] kind,
			input logic [sab_pkg::ADDR_W-1:0] addr,
			input logic typed, input sab_pkg::result_t want);
		int gap;
		sab_pkg::result_t predicted;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		predicted = predict_blocklist(kind, addr);
		expected_results.push_back(typed ? want : predicted);
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [sab_pkg::COUNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		limit_model = value;
		settings++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch at %0t: %s expected %0d, got %0d",
				$realtime, what, want, got);
	endtask

	initial begin : receiver
		int stall;
		sab_pkg::result_t got;
		sab_pkg::result_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata[sab_pkg::RESULT_W-1:0];
			n_drop += got.drop;
			n_full += got.table_full;
			if (got.attempt_count == sab_pkg::COUNT_MAX)
				n_sat++;
			if (expected_results.size() == 0) begin
				note_mismatch("unrequested result, found flag", 0, got.found);
			end else begin
				want = expected_results.pop_front();
				if (got.found != want.found)
					note_mismatch("found", want.found, got.found);
				if (got.drop != want.drop)
					note_mismatch("drop", want.drop, got.drop);
				if (got.over_limit != want.over_limit)
					note_mismatch("over_limit", want.over_limit, got.over_limit);
				if (got.table_full != want.table_full)
					note_mismatch("table_full", want.table_full, got.table_full);
				if (got.attempt_count != want.attempt_count)
					note_mismatch("attempt_count", want.attempt_count,
						got.attempt_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int row;
		int phase;
		int phase_end;
		int fails;
		logic [sab_pkg::KIND_W-1:0] kind;
		logic [sab_pkg::ADDR_W-1:0] addr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_N; row++)
			send_request(DIRECTED_ROWS[row].kind, DIRECTED_ROWS[row].addr,
				DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
		wait_drained();

		write_limit(8'd255);
		repeat (258) send_request(sab_pkg::KIND_FAIL, 32'hFFFF_FFFF, 1'b0, NOTHING);
		send_request(sab_pkg::KIND_CHECK, 32'hFFFF_FFFF, 1'b0, NOTHING);
		wait_drained();

		for (phase = 0; phase < 5; phase++) begin
			wait_drained();
			case (phase)
				0: write_limit(8'd0);
				1: write_limit(8'd254);
				2: write_limit(8'($urandom_range(1, 253)));
				3: write_limit(8'd255);
				default: write_limit(8'($urandom_range(0, 255)));
			endcase
			steady = (phase == 2);
			phase_end = sent + PHASE_REQUESTS;
			while (sent < phase_end) begin
				if ($urandom_range(0, 49) == 0)
					wait_drained();
				if ($urandom_range(0, 9) < 7) begin
					if (n_used > 0 && $urandom_range(0, 1) == 1)
						addr = tbl_addr[$urandom_range(0, n_used - 1)];
					else
						addr = $urandom;
					send_request(sab_pkg::KIND_ADD, addr, 1'b0, NOTHING);
					fails = $urandom_range(0, 6);
					repeat (fails) send_request(sab_pkg::KIND_FAIL, addr, 1'b0, NOTHING);
					send_request(sab_pkg::KIND_CHECK, addr, 1'b0, NOTHING);
				end else begin
					kind = ($urandom_range(0, 9) == 0) ?
						KIND_UNUSED : 2'($urandom_range(0, 2));
					addr = $urandom;
					if (n_used > 0 && $urandom_range(0, 2) != 0) begin
						addr = tbl_addr[$urandom_range(0, n_used - 1)];
						if ($urandom_range(0, 1) == 1)
							addr = addr ^ (32'd1 << $urandom_range(0, 31));
					end
					send_request(kind, addr, 1'b0, NOTHING);
				end
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		$display("Sent %0d requests under %0d limit settings; the table held %0d of %0d entries.",
			sent, settings, n_used, TABLE_DEPTH);
		$display("Seen %0d drops, %0d refused adds, %0d saturated counts and %0d mismatches.",
			n_drop, n_full, n_sat, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
